@@ rtl/esc_reply_deframer_checksum_core_macros.svh @@
// Assertion shorthands shared by the deframer RTL.
`ifndef ESC_REPLY_DEFRAMER_CHECKSUM_CORE_MACROS_SVH
`define ESC_REPLY_DEFRAMER_CHECKSUM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ERD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ERD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/erd_pkg.sv @@
`default_nettype none

package erd_pkg;

   // Frame limits and derived widths.
   localparam int MAX_DATA = 1024;
   localparam int CNT_W = $clog2(MAX_DATA + 4);
   localparam int IDX_W = 10;
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DATA + 3);
   localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(3);

   // Link bytes.
   localparam logic [7:0] ESC_BYTE   = 8'h1B;
   localparam logic [7:0] ACK_BYTE   = 8'h06;
   localparam logic [7:0] NAK_BYTE   = 8'h15;
   localparam logic [7:0] ETX_BYTE   = 8'h03;
   localparam logic [7:0] CTRL_LIMIT = 8'h20;

   // Operations passed from the front to the back.
   localparam logic [2:0] OP_IDLE    = 3'd0;
   localparam logic [2:0] OP_START   = 3'd1;
   localparam logic [2:0] OP_BODY    = 3'd2;
   localparam logic [2:0] OP_PAIR    = 3'd3;
   localparam logic [2:0] OP_ETX     = 3'd4;
   localparam logic [2:0] OP_END     = 3'd5;
   localparam logic [2:0] OP_RESTART = 3'd6;

   // Result codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_CHK   = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;
   localparam logic [1:0] ST_OVF   = 2'd3;
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] data;
   } op_type;

   typedef struct packed {
      logic [7:0]       sum;
      logic [CNT_W-1:0] cnt;
      logic [7:0]       prn_status;
      logic [7:0]       cmd_status;
      logic [7:0]       cmd;
      logic             ovf;
   } frame_type;

   typedef struct packed {
      frame_type        frame;
      logic             emit;
      logic [IDX_W-1:0] idx;
   } accept_type;

   localparam frame_type FRAME_CLEAR = '0;

   // Takes one decoded body byte into the frame state.
   function automatic accept_type body_accept(frame_type f, logic [7:0] b);
      accept_type       r;
      logic [CNT_W-1:0] rel;
      r       = '0;
      r.frame = f;
      rel     = f.cnt - HDR_BYTES;
      r.frame.sum = f.sum + b;
      if (f.cnt == CNT_W'(0)) begin
         r.frame.prn_status = b;
      end else if (f.cnt == CNT_W'(1)) begin
         r.frame.cmd_status = b;
      end else if (f.cnt == CNT_W'(2)) begin
         r.frame.cmd = b;
      end else if (f.cnt >= CNT_LIMIT) begin
         r.frame.ovf = 1'b1;
      end else begin
         r.emit = 1'b1;
         r.idx  = IDX_W'(rel);
      end
      if (f.cnt < CNT_LIMIT) begin
         r.frame.cnt = f.cnt + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/erd_front.sv @@
`default_nettype none

module erd_front
   import erd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       take,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_restart,
   output op_type          op_out
);

   localparam logic [2:0] PH_HUNT     = 3'd0;
   localparam logic [2:0] PH_HDR      = 3'd1;
   localparam logic [2:0] PH_BODY     = 3'd2;
   localparam logic [2:0] PH_BODY_ESC = 3'd3;
   localparam logic [2:0] PH_CHK      = 3'd4;
   localparam logic [2:0] PH_CHK_ESC  = 3'd5;

   logic [2:0] phase_ff;
   logic [2:0] phase_in;

   // Track escape pairing and classify each byte into one operation.
   always_comb begin
      phase_in    = phase_ff;
      op_out.op   = OP_IDLE;
      op_out.data = req_rx_byte;
      if (req_restart) begin
         op_out.op = OP_RESTART;
         phase_in  = PH_HUNT;
      end else begin
         unique case (phase_ff)
            PH_HDR: begin
               if (req_rx_byte == ACK_BYTE || req_rx_byte == NAK_BYTE) begin
                  op_out.op = OP_START;
                  phase_in  = PH_BODY;
               end else if (req_rx_byte != ESC_BYTE) begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (req_rx_byte == ESC_BYTE) begin
                  phase_in = PH_BODY_ESC;
               end else begin
                  op_out.op = OP_BODY;
               end
            end
            PH_BODY_ESC: begin
               phase_in = PH_BODY;
               if (req_rx_byte == ETX_BYTE) begin
                  op_out.op = OP_ETX;
                  phase_in  = PH_CHK;
               end else if (req_rx_byte < CTRL_LIMIT || req_rx_byte == ESC_BYTE) begin
                  op_out.op = OP_BODY;
               end else begin
                  op_out.op = OP_PAIR;
               end
            end
            PH_CHK: begin
               if (req_rx_byte == ESC_BYTE) begin
                  phase_in = PH_CHK_ESC;
               end else begin
                  op_out.op = OP_END;
                  phase_in  = PH_HUNT;
               end
            end
            PH_CHK_ESC: begin
               op_out.op = OP_END;
               phase_in  = PH_HUNT;
            end
            default: begin
               phase_in = (req_rx_byte == ESC_BYTE) ? PH_HDR : PH_HUNT;
            end
         endcase
      end
   end

   // The phase advances once per accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else if (take) begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/erd_queue.sv @@
`default_nettype none
`include "esc_reply_deframer_checksum_core_macros.svh"

module erd_queue
   import erd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   input  wire logic   pop,
   output op_type      head_op,
   output logic        full,
   output logic        empty
);

   op_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head_op = slots_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_op;
      end
   end

   `ERD_ASSERT_IMP(a_no_push_when_full, clock, reset, full, !push, "push into a full queue")
   `ERD_ASSERT_IMP(a_no_pop_when_empty, clock, reset, empty, !pop, "pop from an empty queue")

endmodule

`default_nettype wire

@@ rtl/erd_back.sv @@
`default_nettype none
`include "esc_reply_deframer_checksum_core_macros.svh"

module erd_back
   import erd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire op_type           head_op,
   input  wire logic             q_empty,
   output logic                  pop,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [IDX_W-1:0]      rsp_data_index,
   output logic                  rsp_is_ack,
   output logic [7:0]            rsp_printer_status,
   output logic [7:0]            rsp_command_status,
   output logic [7:0]            rsp_cmd_id,
   output logic                  rsp_cmd_match,
   output logic [1:0]            rsp_frame_status
);

   frame_type        frame_ff;
   frame_type        frame_in;
   logic             ack_ff;
   logic             ack_in;
   logic [7:0]       expected_cmd_ff;
   logic             hold_valid_ff;
   logic             hold_valid_in;
   logic [7:0]       hold_byte_ff;
   logic [7:0]       hold_byte_in;
   logic [IDX_W-1:0] hold_idx_ff;
   logic [IDX_W-1:0] hold_idx_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_kind_ff;
   logic [7:0]       rsp_data_byte_ff;
   logic [IDX_W-1:0] rsp_data_index_ff;
   logic             rsp_is_ack_ff;
   logic [7:0]       rsp_printer_status_ff;
   logic [7:0]       rsp_command_status_ff;
   logic [7:0]       rsp_cmd_id_ff;
   logic             rsp_cmd_match_ff;
   logic [1:0]       rsp_frame_status_ff;

   logic [7:0]       first_byte;
   accept_type       acc1;
   accept_type       acc2;
   logic             c1_valid;
   logic             c2_valid;
   logic [7:0]       c2_byte;
   logic             end_item;
   logic             drop_hold;
   logic             data_valid;
   logic [7:0]       data_byte;
   logic [IDX_W-1:0] data_idx;
   logic [7:0]       chk_total;
   logic [1:0]       status;
   logic             match;

   // The back advances when an operation waits and the output register is free.
   assign pop = !q_empty && (!rsp_valid_ff || !rsp_stall);

   // Execute one operation against the frame state.
   always_comb begin
      first_byte = (head_op.op == OP_PAIR) ? ESC_BYTE : head_op.data;
      acc1       = body_accept(frame_ff, first_byte);
      acc2       = body_accept(acc1.frame, head_op.data);
      frame_in   = frame_ff;
      ack_in     = ack_ff;
      c1_valid   = 1'b0;
      c2_valid   = 1'b0;
      c2_byte    = head_op.data;
      end_item   = 1'b0;
      drop_hold  = 1'b0;
      unique case (head_op.op)
         OP_START: begin
            frame_in     = FRAME_CLEAR;
            frame_in.sum = head_op.data;
            ack_in       = (head_op.data == ACK_BYTE);
         end
         OP_BODY: begin
            frame_in = acc1.frame;
            c1_valid = acc1.emit;
         end
         OP_PAIR: begin
            frame_in = acc2.frame;
            c1_valid = acc1.emit;
            c2_valid = acc2.emit;
         end
         OP_ETX: begin
            frame_in.sum = frame_ff.sum + ETX_BYTE;
         end
         OP_END: begin
            frame_in  = FRAME_CLEAR;
            ack_in    = 1'b0;
            end_item  = 1'b1;
            drop_hold = 1'b1;
         end
         OP_RESTART: begin
            frame_in  = FRAME_CLEAR;
            ack_in    = 1'b0;
            drop_hold = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // A held byte leaves first unless END or RESTART drops it; a second decoded byte waits one transaction.
   always_comb begin
      data_valid    = 1'b0;
      data_byte     = first_byte;
      data_idx      = acc1.idx;
      hold_valid_in = 1'b0;
      hold_byte_in  = c2_byte;
      hold_idx_in   = acc2.idx;
      if (hold_valid_ff) begin
         data_valid    = 1'b1;
         data_byte     = hold_byte_ff;
         data_idx      = hold_idx_ff;
         hold_valid_in = c1_valid || c2_valid;
         if (c1_valid) begin
            hold_byte_in = first_byte;
            hold_idx_in  = acc1.idx;
         end
      end else if (c1_valid) begin
         data_valid    = 1'b1;
         hold_valid_in = c2_valid;
      end else begin
         data_valid = c2_valid;
         data_byte  = c2_byte;
         data_idx   = acc2.idx;
      end
      if (drop_hold) begin
         data_valid    = 1'b0;
         hold_valid_in = 1'b0;
      end
   end

   // End-of-frame verdict: too short, then overflow, then checksum.
   always_comb begin
      chk_total = frame_ff.sum + head_op.data;
      if (frame_ff.cnt < HDR_BYTES) begin
         status = ST_SHORT;
      end else if (frame_ff.ovf) begin
         status = ST_OVF;
      end else if (chk_total != 8'h00) begin
         status = ST_CHK;
      end else begin
         status = ST_OK;
      end
      match = (status != ST_SHORT) && (frame_ff.cmd == expected_cmd_ff);
      rsp_valid_in = pop ? (end_item || data_valid) : (rsp_valid_ff && rsp_stall);
   end

   // Control and frame state.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff        <= FRAME_CLEAR;
         ack_ff          <= 1'b0;
         hold_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         expected_cmd_ff <= 8'h00;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            expected_cmd_ff <= csr_wr_data;
         end
         if (pop) begin
            frame_ff      <= frame_in;
            ack_ff        <= ack_in;
            hold_valid_ff <= hold_valid_in;
         end
      end
   end

   // Payload registers for the held byte and the output transaction.
   always_ff @(posedge clock) begin
      if (pop) begin
         hold_byte_ff <= hold_byte_in;
         hold_idx_ff  <= hold_idx_in;
         if (end_item) begin
            rsp_kind_ff           <= KIND_END;
            rsp_data_byte_ff      <= 8'h00;
            rsp_data_index_ff     <= '0;
            rsp_is_ack_ff         <= ack_ff;
            rsp_printer_status_ff <= frame_ff.prn_status;
            rsp_command_status_ff <= frame_ff.cmd_status;
            rsp_cmd_id_ff         <= frame_ff.cmd;
            rsp_cmd_match_ff      <= match;
            rsp_frame_status_ff   <= status;
         end else begin
            rsp_kind_ff           <= KIND_DATA;
            rsp_data_byte_ff      <= data_byte;
            rsp_data_index_ff     <= data_idx;
            rsp_is_ack_ff         <= 1'b0;
            rsp_printer_status_ff <= 8'h00;
            rsp_command_status_ff <= 8'h00;
            rsp_cmd_id_ff         <= 8'h00;
            rsp_cmd_match_ff      <= 1'b0;
            rsp_frame_status_ff   <= ST_OK;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_data_byte      = rsp_data_byte_ff;
   assign rsp_data_index     = rsp_data_index_ff;
   assign rsp_is_ack         = rsp_is_ack_ff;
   assign rsp_printer_status = rsp_printer_status_ff;
   assign rsp_command_status = rsp_command_status_ff;
   assign rsp_cmd_id         = rsp_cmd_id_ff;
   assign rsp_cmd_match      = rsp_cmd_match_ff;
   assign rsp_frame_status   = rsp_frame_status_ff;

   `ERD_ASSERT_IMP(a_hold_has_data, clock, reset, hold_valid_ff, frame_ff.cnt >= CNT_W'(4), "held byte without data in frame")
   `ERD_ASSERT_NXT(a_restart_clears, clock, reset, pop && head_op.op == OP_RESTART, !hold_valid_ff && frame_ff.cnt == '0 && !rsp_valid_ff, "restart left frame state behind")

endmodule

`default_nettype wire

@@ rtl/esc_reply_deframer_checksum_core.sv @@
// Reply deframer for an ESC byte-stuffed link with a two's-complement checksum.
// Input channel (req_*): one received byte per transaction; req_restart drops any
// partial frame and returns to hunting for ESC ACK or ESC NAK.
// Output channel (rsp_*): data transactions (rsp_kind 0) carry unescaped payload
// bytes with their index, and are provisional until the end-of-frame transaction
// (rsp_kind 1) reports ack flag, status bytes, command id, match and verdict.
// Configuration: csr_wr_en writes csr_wr_data as the expected command id.
// Throughput is one byte per cycle while req_stall is low. A byte's result is
// registered in the queue and then in the output register; after an escaped
// pair the second data byte trails by one transaction.
// A 4-entry queue separates the byte classifier from the back end; with rsp_stall
// held, bytes are taken until all four entries are full and req_stall rises.
// Reset (synchronous) returns to hunting, empties the queue, clears rsp_valid
// and sets the expected command id to zero.
`default_nettype none

module esc_reply_deframer_checksum_core
   import erd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [7:0]       req_rx_byte,
   input  wire logic             req_restart,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic                  rsp_kind,
   output logic [7:0]            rsp_data_byte,
   output logic [IDX_W-1:0]      rsp_data_index,
   output logic                  rsp_is_ack,
   output logic [7:0]            rsp_printer_status,
   output logic [7:0]            rsp_command_status,
   output logic [7:0]            rsp_cmd_id,
   output logic                  rsp_cmd_match,
   output logic [1:0]            rsp_frame_status,
   input  wire logic             csr_wr_en,
   input  wire logic [7:0]       csr_wr_data
);

   logic   take;
   logic   q_full;
   logic   q_empty;
   logic   pop;
   op_type front_op;
   op_type head_op;

   // A transaction is taken whenever the queue has room.
   assign req_stall = q_full;
   assign take      = req_valid && !q_full;

   erd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_rx_byte (req_rx_byte),
      .req_restart (req_restart),
      .op_out      (front_op)
   );

   erd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (take),
      .push_op (front_op),
      .pop     (pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   erd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_op            (head_op),
      .q_empty            (q_empty),
      .pop                (pop),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_data_index     (rsp_data_index),
      .rsp_is_ack         (rsp_is_ack),
      .rsp_printer_status (rsp_printer_status),
      .rsp_command_status (rsp_command_status),
      .rsp_cmd_id         (rsp_cmd_id),
      .rsp_cmd_match      (rsp_cmd_match),
      .rsp_frame_status   (rsp_frame_status)
   );

endmodule

`default_nettype wire
